>>> sv/sbs_pkg.sv
// Shared constants and types for the sorted pair binary search block.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

  // defaults for the top level parameters
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned SymbolBitsDef = 32;

  // fixed field widths
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned PosW    = 11;
  localparam int unsigned InDataW = 80;  // index + two keys, padded to bytes
  localparam int unsigned OutDataW = 16; // found + position, padded to bytes

  // command codes carried in tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // outcome of one lexicographic probe compare
  typedef struct packed {
    logic key_after;   // key pair sorts strictly after the entry
    logic key_before;  // key pair sorts strictly before the entry
  } cmp_res_t;

endpackage

`default_nettype wire

>>> sv/sorted_pair_binary_search.sv
// Top level: streaming ports around the pair table, compare unit and sequencer.
// Load item: written to the table at the edge that accepts it, no result.
// Search item: accept, the setup state, then the probes, one probe per cycle (at most
// ceil(log2(count+1)), 11 for 1024 entries), then the finish state, which waits for
// the output register to drain; no new item is taken until then; one table read port.
// Reset clears entry_count to 0 and the control state; the table itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_pair_binary_search #(
  parameter int unsigned TableDepth = sbs_pkg::TableDepthDef,
  parameter int unsigned SymbolBits = sbs_pkg::SymbolBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sbs_pkg::CountW-1:0]     cfg_wdata_i,   // entry_count
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_index [9:0], key_left [41:10], key_right [73:42], zero pad [79:74]
  input  wire logic [sbs_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire logic [0:0]                     s_axis_tuser,  // command [0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // found [0], position [11:1], zero pad [15:12]
  output logic [sbs_pkg::OutDataW-1:0]        m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned KeyLo = sbs_pkg::IndexW;
  localparam int unsigned KeyRo = sbs_pkg::IndexW + sbs_pkg::KeyW;

  logic [sbs_pkg::IndexW-1:0] in_index;
  logic [SymbolBits-1:0]      in_left, in_right;
  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [2*SymbolBits-1:0]    ram_rdata;
  logic [SymbolBits-1:0]      key_left, key_right;
  sbs_pkg::cmp_res_t          cmp_res;
  logic                       out_found;
  logic [sbs_pkg::PosW-1:0]   out_pos;

  // symbols are kept to SymbolBits on both load and search
  assign in_index = s_axis_tdata[sbs_pkg::IndexW-1:0];
  assign in_left  = s_axis_tdata[KeyLo +: SymbolBits];
  assign in_right = s_axis_tdata[KeyRo +: SymbolBits];

  sbs_pair_ram #(
    .Depth (TableDepth),
    .DataW (2 * SymbolBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_right, in_left}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sbs_pair_cmp #(
    .SymbolBits (SymbolBits)
  ) u_cmp (
    .key_left_i  (key_left),
    .key_right_i (key_right),
    .ent_left_i  (ram_rdata[SymbolBits-1:0]),
    .ent_right_i (ram_rdata[2*SymbolBits-1:SymbolBits]),
    .res_o       (cmp_res)
  );

  sbs_seq #(
    .TableDepth (TableDepth),
    .SymbolBits (SymbolBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_index_i  (in_index),
    .in_left_i   (in_left),
    .in_right_i  (in_right),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (out_found),
    .out_pos_o   (out_pos),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .key_left_o  (key_left),
    .key_right_o (key_right),
    .cmp_i       (cmp_res)
  );

  assign m_axis_tdata = {(sbs_pkg::OutDataW - sbs_pkg::PosW - 1)'(0), out_pos, out_found};

endmodule

`default_nettype wire

>>> sv/sbs_pair_ram.sv
// Single write port, single registered read port table of symbol pairs.
`timescale 1ns / 1ps
`default_nettype none

module sbs_pair_ram #(
  parameter int unsigned Depth = sbs_pkg::TableDepthDef,
  parameter int unsigned DataW = 2 * sbs_pkg::SymbolBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [DataW-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/sbs_pair_cmp.sv
// Lexicographic compare of the search key pair against one table entry.
`timescale 1ns / 1ps
`default_nettype none

module sbs_pair_cmp #(
  parameter int unsigned SymbolBits = sbs_pkg::SymbolBitsDef
) (
  input  wire logic [SymbolBits-1:0] key_left_i,
  input  wire logic [SymbolBits-1:0] key_right_i,
  input  wire logic [SymbolBits-1:0] ent_left_i,
  input  wire logic [SymbolBits-1:0] ent_right_i,
  output sbs_pkg::cmp_res_t          res_o
);

  logic left_eq;

  assign left_eq = (key_left_i == ent_left_i);

  always_comb begin
    res_o.key_after  = (key_left_i > ent_left_i) || (left_eq && (key_right_i > ent_right_i));
    res_o.key_before = (key_left_i < ent_left_i) || (left_eq && (key_right_i < ent_right_i));
  end

endmodule

`default_nettype wire

>>> sv/sbs_seq.sv
// Search sequencer: holds bounds, issues one table read per probe, drives results.
`timescale 1ns / 1ps
`default_nettype none

module sbs_seq #(
  parameter int unsigned TableDepth = sbs_pkg::TableDepthDef,
  parameter int unsigned SymbolBits = sbs_pkg::SymbolBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [sbs_pkg::CountW-1:0]    cfg_wdata_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          in_cmd_i,
  input  wire logic [sbs_pkg::IndexW-1:0]    in_index_i,
  input  wire logic [SymbolBits-1:0]         in_left_i,
  input  wire logic [SymbolBits-1:0]         in_right_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_found_o,
  output logic [sbs_pkg::PosW-1:0]           out_pos_o,
  // table access
  output logic                               ram_we_o,
  output logic [$clog2(TableDepth)-1:0]      ram_waddr_o,
  output logic                               ram_re_o,
  output logic [$clog2(TableDepth)-1:0]      ram_raddr_o,
  // compare unit
  output logic [SymbolBits-1:0]              key_left_o,
  output logic [SymbolBits-1:0]              key_right_o,
  input  wire sbs_pkg::cmp_res_t             cmp_i
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned PtrW  = $clog2(TableDepth + 1);
  localparam int unsigned CntW  = (PtrW > sbs_pkg::CountW) ? PtrW : sbs_pkg::CountW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [sbs_pkg::CountW-1:0] count_q, count_d;
  logic [CntW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [SymbolBits-1:0]     kl_q, kl_d, kr_q, kr_d;
  logic                      res_found_q, res_found_d;
  logic [CntW-1:0]           res_pos_q, res_pos_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [sbs_pkg::PosW-1:0]  out_pos_q, out_pos_d;

  logic                      accept;
  logic [CntW-1:0]           count_eff;
  logic [CntW-1:0]           lo_n, hi_n, sel_lo, sel_hi, mid_n;
  logic [CntW:0]             mid_sum;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign count_eff = (CntW'(count_q) > CntW'(TableDepth)) ? CntW'(TableDepth)
                                                          : CntW'(count_q);

  // probe bounds after this cycle's compare
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (cmp_i.key_after) begin
      lo_n = mid_q + CntW'(1);
    end else if (cmp_i.key_before) begin
      hi_n = mid_q;
    end
  end

  // shared midpoint adder: floor((lo + hi - 1) / 2), only used while lo < hi
  assign sel_lo  = (state_q == ST_START) ? lo_q : lo_n;
  assign sel_hi  = (state_q == ST_START) ? hi_q : hi_n;
  assign mid_sum = {1'b0, sel_lo} + {1'b0, sel_hi} - (CntW + 1)'(1);
  assign mid_n   = mid_sum[CntW:1];

  always_comb begin
    state_d     = state_q;
    count_d     = cfg_we_i ? cfg_wdata_i : count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    kl_d        = kl_q;
    kr_d        = kr_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = AddrW'(mid_n);

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_cmd_i == sbs_pkg::CMD_SEARCH)) begin
          kl_d    = in_left_i;
          kr_d    = in_right_i;
          lo_d    = '0;
          hi_d    = count_eff;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (lo_q < hi_q) begin
          ram_re_o = 1'b1;
          mid_d    = mid_n;
          state_d  = ST_PROBE;
        end else begin
          res_found_d = 1'b0;
          res_pos_d   = lo_q;
          state_d     = ST_FINISH;
        end
      end
      ST_PROBE: begin
        if (!cmp_i.key_after && !cmp_i.key_before) begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q;
          state_d     = ST_FINISH;
        end else if (lo_n < hi_n) begin
          ram_re_o = 1'b1;
          lo_d     = lo_n;
          hi_d     = hi_n;
          mid_d    = mid_n;
        end else begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          res_found_d = 1'b0;
          res_pos_d   = lo_n;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = sbs_pkg::PosW'(res_pos_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      kl_q        <= '0;
      kr_q        <= '0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      kl_q        <= kl_d;
      kr_q        <= kr_d;
      res_found_q <= res_found_d;
      res_pos_q   <= res_pos_d;
      out_valid_q <= out_valid_d;
      out_found_q <= out_found_d;
      out_pos_q   <= out_pos_d;
    end
  end

  // loads write straight through; out-of-range indexes are dropped
  assign ram_we_o    = accept && (in_cmd_i == sbs_pkg::CMD_LOAD)
                       && (32'(in_index_i) < 32'(TableDepth));
  assign ram_waddr_o = AddrW'(in_index_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;
  assign key_left_o  = kl_q;
  assign key_right_o = kr_q;

  a_probe_in_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> ((mid_q >= lo_q) && (mid_q < hi_q)))
    else $error("probe index outside search window");

  a_window_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PROBE) || (state_q == ST_START)) |-> (lo_q <= hi_q))
    else $error("search window inverted");

  a_hi_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |=> (hi_q <= $past(hi_q)))
    else $error("upper bound grew during search");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("table write and probe read in the same cycle");

endmodule

`default_nettype wire

>>> dv/sorted_pair_binary_search_test.sv
// Stream testbench for the sorted pair binary search block with a result scoreboard.
`timescale 1ns / 1ps

module sorted_pair_binary_search_test;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HALF_DEPTH    = sbs_pkg::TableDepthDef / 2;
  localparam logic [sbs_pkg::KeyW-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic                     found;
    logic [sbs_pkg::PosW-1:0] position;
  } search_res_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_SEARCH, ROW_COUNT} row_kind_e;

  // arg is the entry index for a load and the new entry_count for a count row
  typedef struct packed {
    row_kind_e                  kind;
    logic [sbs_pkg::CountW-1:0] arg;
    logic [sbs_pkg::KeyW-1:0]   left;
    logic [sbs_pkg::KeyW-1:0]   right;
    logic                       typed;
    logic                       found;
    logic [sbs_pkg::PosW-1:0]   position;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sbs_pkg::CountW-1:0] cfg_wdata = '0;
  logic s_valid = 1'b0;
  logic [sbs_pkg::InDataW-1:0] s_data = '0;
  logic [0:0] s_user = '0;
  logic m_ready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [sbs_pkg::OutDataW-1:0] m_axis_tdata;

  // mirror of the block state
  logic [sbs_pkg::KeyW-1:0]   tbl_left [sbs_pkg::TableDepthDef];
  logic [sbs_pkg::KeyW-1:0]   tbl_right [sbs_pkg::TableDepthDef];
  logic [sbs_pkg::CountW-1:0] entry_count_q = '0;

  search_res_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;

  dir_row_t directed_rows [20] = '{
    // empty table
    '{ROW_SEARCH, 11'd0, 32'd5, 32'd5, 1'b1, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, KEY_MAX, KEY_MAX, 1'b1, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd0, 32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd1, 32'd0, KEY_MAX, 1'b0, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd2, 32'd1, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd3, KEY_MAX, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd4, KEY_MAX, KEY_MAX, 1'b0, 1'b0, 11'd0},
    '{ROW_LOAD, 11'd1023, KEY_MAX, KEY_MAX, 1'b0, 1'b0, 11'd0},
    '{ROW_COUNT, 11'd1, 32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'd0, 32'd0, 1'b1, 1'b1, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'd0, 32'd1, 1'b1, 1'b0, 11'd1},
    '{ROW_SEARCH, 11'd0, KEY_MAX, KEY_MAX, 1'b1, 1'b0, 11'd1},
    '{ROW_COUNT, 11'd5, 32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'd0, 32'd0, 1'b1, 1'b1, 11'd0},
    '{ROW_SEARCH, 11'd0, KEY_MAX, KEY_MAX, 1'b1, 1'b1, 11'd4},
    '{ROW_SEARCH, 11'd0, 32'd0, KEY_MAX, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'd1, 32'd0, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'hFFFF_FFFE, KEY_MAX, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, KEY_MAX, 32'd1, 1'b0, 1'b0, 11'd0},
    '{ROW_SEARCH, 11'd0, 32'd2, 32'd0, 1'b0, 1'b0, 11'd0}
  };

  sorted_pair_binary_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexicographic binary search over the mirrored table
  function automatic search_res_t locate_pair(input logic [sbs_pkg::KeyW-1:0] kl,
                                              input logic [sbs_pkg::KeyW-1:0] kr);
    int lo, hi, mid, span;
    search_res_t res;
    span = (entry_count_q > sbs_pkg::TableDepthDef) ? sbs_pkg::TableDepthDef
                                                     : int'(entry_count_q);
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (kl > tbl_left[mid] || (kl == tbl_left[mid] && kr > tbl_right[mid])) begin
        lo = mid + 1;
      end else if (kl < tbl_left[mid] || (kl == tbl_left[mid] && kr < tbl_right[mid])) begin
        hi = mid - 1;
      end else begin
        res.found = 1'b1;
        res.position = sbs_pkg::PosW'(mid);
        return res;
      end
    end
    res.found = 1'b0;
    res.position = sbs_pkg::PosW'(lo);
    return res;
  endfunction

  task automatic send_item(input logic cmd, input logic [sbs_pkg::IndexW-1:0] idx,
                           input logic [sbs_pkg::KeyW-1:0] kl,
                           input logic [sbs_pkg::KeyW-1:0] kr,
                           input bit typed, input search_res_t typed_res);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 35) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user = cmd;
    s_data = {6'b0, kr, kl, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (cmd == sbs_pkg::CMD_LOAD) begin
      tbl_left[idx] = kl;
      tbl_right[idx] = kr;
    end else begin
      pending_results.insert(pending_results.size(),
                             typed ? typed_res : locate_pair(kl, kr));
    end
  endtask

  // loads leave no result behind, so give the block its full latency afterwards
  task automatic wait_quiet();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_entry_count(input logic [sbs_pkg::CountW-1:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    entry_count_q = value;
  endtask

  // load a sorted run into entries 0..n_load-1, set the count, then mostly searches
  task automatic table_phase(input int unsigned n_load, input int unsigned n_ops,
                             input logic [sbs_pkg::CountW-1:0] count_val, input bit hold);
    logic [sbs_pkg::KeyW-1:0] cur_l, cur_r, kl, kr;
    longint unsigned step_max;
    int unsigned eff, pick, sel;
    cur_l = $urandom_range(0, 32'h7FFF_FFFF);
    cur_r = $urandom_range(0, 32'hFFFF_0000);
    step_max = (64'hFFFF_FFFF - cur_l) / (n_load + 1);
    for (int i = 0; i < n_load; i++) begin
      if (i != 0) begin
        // half the time keep the left symbol so the right one decides
        if ($urandom_range(1) == 0) begin
          cur_r += $urandom_range(0, 3);
        end else begin
          cur_l += $urandom_range(1, 32'(step_max));
          cur_r = $urandom_range(0, 32'hFFFF_0000);
        end
      end
      send_item(sbs_pkg::CMD_LOAD, sbs_pkg::IndexW'(i), cur_l, cur_r, 1'b0, '0);
      if (n_load < sbs_pkg::TableDepthDef && $urandom_range(19) == 0) begin
        send_item(sbs_pkg::CMD_LOAD,
                  sbs_pkg::IndexW'($urandom_range(n_load, sbs_pkg::TableDepthDef - 1)),
                  $urandom(), $urandom(), 1'b0, '0);
      end
    end
    wait_quiet();
    set_entry_count(count_val);
    if (hold) hold_request = 1'b1;
    eff = (count_val > sbs_pkg::TableDepthDef) ? sbs_pkg::TableDepthDef : count_val;
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(99);
      pick = (eff != 0) ? $urandom_range(0, eff - 1) : 0;
      kl = tbl_left[pick];
      kr = tbl_right[pick];
      if (sel < 5) begin
        // stray write, may break the ordering inside the searched range
        send_item(sbs_pkg::CMD_LOAD,
                  sbs_pkg::IndexW'($urandom_range(0, sbs_pkg::TableDepthDef - 1)),
                  $urandom(), $urandom(), 1'b0, '0);
      end else begin
        if (eff == 0 || sel >= 85) begin
          kl = $urandom();
          kr = $urandom();
        end else if (sel >= 75) begin
          kl = sel[0] ? kl + 1 : kl - 1;
        end else if (sel >= 60) begin
          kr = sel[0] ? kr + 1 : kr - 1;
        end
        send_item(sbs_pkg::CMD_SEARCH, '0, kl, kr, 1'b0, '0);
      end
    end
  endtask

  // searches only, keys taken from entries below lim or at random
  task automatic search_phase(input int unsigned lim, input int unsigned n_ops,
                              input logic [sbs_pkg::CountW-1:0] count_val);
    logic [sbs_pkg::KeyW-1:0] kl, kr;
    int unsigned pick;
    wait_quiet();
    set_entry_count(count_val);
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, lim - 1);
      kl = tbl_left[pick];
      kr = tbl_right[pick];
      if ($urandom_range(1) == 0) begin
        kl = $urandom();
        kr = $urandom();
      end
      send_item(sbs_pkg::CMD_SEARCH, '0, kl, kr, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      m_ready = 1'b0;
      hold_left--;
    end else begin
      m_ready = !(gaps_on && $urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin : result_check
    search_res_t got, want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got.found = m_axis_tdata[0];
      got.position = m_axis_tdata[sbs_pkg::PosW:1];
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0d, position %0d", got.found, got.position);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          mismatch_count++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, got.position);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no, n;
    logic [sbs_pkg::CountW-1:0] cv;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_COUNT: begin
          wait_quiet();
          set_entry_count(directed_rows[r].arg);
        end
        ROW_LOAD: begin
          send_item(sbs_pkg::CMD_LOAD, directed_rows[r].arg[sbs_pkg::IndexW-1:0],
                    directed_rows[r].left, directed_rows[r].right, 1'b0, '0);
        end
        default: begin
          send_item(sbs_pkg::CMD_SEARCH, '0, directed_rows[r].left, directed_rows[r].right,
                    directed_rows[r].typed,
                    search_res_t'({directed_rows[r].found, directed_rows[r].position}));
        end
      endcase
    end
    wait_quiet();

    phase_no = 0;
    while (items_sent < 150 || phase_no < 3) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
      case ($urandom_range(5))
        0: cv = '0;
        1: cv = sbs_pkg::CountW'($urandom_range(0, n));
        default: cv = sbs_pkg::CountW'(n);
      endcase
      // every fifth phase runs with no gaps on either side
      gaps_on = (phase_no % 5 != 4);
      table_phase(n, 30, cv, phase_no == 2);
      phase_no++;
    end

    // lower half loaded with no gaps, topped by the largest pair so that searches over
    // the full depth or an oversized count never probe above it
    gaps_on = 1'b0;
    table_phase(HALF_DEPTH, 40, sbs_pkg::CountW'(HALF_DEPTH), 1'b0);
    gaps_on = 1'b1;
    send_item(sbs_pkg::CMD_LOAD, sbs_pkg::IndexW'(HALF_DEPTH - 1), KEY_MAX, KEY_MAX,
              1'b0, '0);
    search_phase(HALF_DEPTH, 40, sbs_pkg::CountW'(sbs_pkg::TableDepthDef));
    search_phase(HALF_DEPTH, 40, '1);
    table_phase(0, 10, '0, 1'b0);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sbs_pkg.sv
sv/sbs_pair_ram.sv
sv/sbs_pair_cmp.sv
sv/sbs_seq.sv
sv/sorted_pair_binary_search.sv
dv/sorted_pair_binary_search_test.sv
